[hdl/button_debounce_press_classifier_defines.svh]
// assertion macros for the button debounce press classifier
// no dependencies; included by button_debounce_press_classifier, the module that carries assertions
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define BDPC_ASSERT_IMP(name, clk, rstn, a, b) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (a) |-> (b)) \
        else $error("bdpc assertion failed: same-cycle implication");

// next-cycle implication, disabled while reset is held
`define BDPC_ASSERT_NXT(name, clk, rstn, a, b) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (a) |=> (b)) \
        else $error("bdpc assertion failed: next-cycle implication");

`endif

[hdl/bdpc_pkg.sv]
// constants and types for the button debounce press classifier
// no dependencies
package bdpc_pkg;

    // configuration port geometry
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 2'd1;

    // register widths and reset values
    localparam int DEBOUNCE_W   = 8;
    localparam int LONG_PRESS_W = 16;
    localparam logic [DEBOUNCE_W-1:0]   DEBOUNCE_RESET   = 8'd50;
    localparam logic [LONG_PRESS_W-1:0] LONG_PRESS_RESET = 16'd1000;

    // raw pin level that means pressed
    localparam logic LOW = 1'b0;

    // one result transaction
    typedef struct packed {
        logic pressed;
        logic short_press;
        logic long_press;
    } result_t;

endpackage

[hdl/button_debounce_press_classifier.sv]
// button debouncer with short and long press classification, top level
// depends on bdpc_pkg and button_debounce_press_classifier_defines.svh
//
// usage:
//   s_ channel: one transaction per millisecond tick, s_raw_level is the raw
//   active-low pin level. m_ channel: one result per tick with the debounced
//   state (m_pressed) and one-tick pulses m_short_press and m_long_press.
//   cfg_we/cfg_index/cfg_wdata write debounce_ticks (index 0) and
//   long_press_ticks (index 1); other indexes are ignored. write only while idle.
// timing:
//   a tick is captured in an input register, then one pass of compares and
//   counter increments updates the state and loads the result register.
//   the result register is loaded as the tick leaves the input register; throughput is
//   one tick per cycle while m_ready keeps the result register free.
// reset:
//   synchronous active-low aresetn returns the registers to 50 and 1000, the
//   last raw level to released and all counters and marks to zero.
// stall:
//   a held result keeps its value; the input register still takes one more
//   tick, then s_ready drops until m_ready frees the result register.
`include "button_debounce_press_classifier_defines.svh"

module button_debounce_press_classifier
    import bdpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_raw_level,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_pressed,
    output logic                  m_short_press,
    output logic                  m_long_press,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CMP_W = (COUNT_WIDTH > LONG_PRESS_W) ? COUNT_WIDTH : LONG_PRESS_W;

    // configuration registers
    logic [DEBOUNCE_W-1:0]   debounce_ticks_reg;
    logic [LONG_PRESS_W-1:0] long_press_ticks_reg;

    // input stage
    logic in_valid_reg;
    logic in_raw_reg;

    // block state
    logic                   last_raw_reg, last_raw_next;
    logic [COUNT_WIDTH-1:0] quiet_count_reg, quiet_count_next;
    logic                   debounced_down_reg, debounced_down_next;
    logic [COUNT_WIDTH-1:0] hold_count_reg, hold_count_next;
    logic                   long_fired_reg, long_fired_next;

    // result stage
    logic    out_valid_reg;
    result_t result_reg, result_next;

    logic advance;
    logic accept_in;
    logic now_down;
    logic level_taken;
    logic [COUNT_WIDTH-1:0] hold_inc;

    // handshake
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign accept_in = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ticks_reg   <= DEBOUNCE_RESET;
            long_press_ticks_reg <= LONG_PRESS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS:   debounce_ticks_reg   <= cfg_wdata[DEBOUNCE_W-1:0];
                REG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_wdata[LONG_PRESS_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_in) begin
            in_raw_reg <= s_raw_level;
        end
    end

    // per-tick update: quiet count, hold count, debounce edge, long press
    always_comb begin
        last_raw_next       = last_raw_reg;
        quiet_count_next    = quiet_count_reg;
        debounced_down_next = debounced_down_reg;
        hold_count_next     = hold_count_reg;
        long_fired_next     = long_fired_reg;
        result_next         = '0;

        if (in_raw_reg != last_raw_reg) begin
            last_raw_next    = in_raw_reg;
            quiet_count_next = '0;
        end else if (quiet_count_reg != {COUNT_WIDTH{1'b1}}) begin
            quiet_count_next = quiet_count_reg + 1'b1;
        end

        if (debounced_down_reg) begin
            hold_count_next = hold_inc;
        end

        now_down    = (last_raw_next == LOW);
        level_taken = (quiet_count_next > COUNT_WIDTH'(debounce_ticks_reg));
        if (level_taken) begin
            if (now_down && !debounced_down_reg) begin
                hold_count_next = '0;
                long_fired_next = 1'b0;
            end else if (!now_down && debounced_down_reg && !long_fired_reg) begin
                result_next.short_press = 1'b1;
            end
            debounced_down_next = now_down;
        end

        if (debounced_down_next && !long_fired_next &&
            (CMP_W'(hold_count_next) >= CMP_W'(long_press_ticks_reg))) begin
            long_fired_next        = 1'b1;
            result_next.long_press = 1'b1;
        end

        result_next.pressed = debounced_down_next;
    end

    // saturating hold increment
    assign hold_inc = (hold_count_reg == {COUNT_WIDTH{1'b1}}) ? hold_count_reg
                                                             : hold_count_reg + 1'b1;

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg       <= 1'b1;
            quiet_count_reg    <= '0;
            debounced_down_reg <= 1'b0;
            hold_count_reg     <= '0;
            long_fired_reg     <= 1'b0;
        end else if (advance) begin
            last_raw_reg       <= last_raw_next;
            quiet_count_reg    <= quiet_count_next;
            debounced_down_reg <= debounced_down_next;
            hold_count_reg     <= hold_count_next;
            long_fired_reg     <= long_fired_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_pressed     = result_reg.pressed;
    assign m_short_press = result_reg.short_press;
    assign m_long_press  = result_reg.long_press;

    // checks
    `BDPC_ASSERT_IMP(a_pulses_exclusive, aclk, aresetn, m_valid, !(m_short_press && m_long_press))
    `BDPC_ASSERT_IMP(a_long_while_held, aclk, aresetn, m_valid && m_long_press, m_pressed)
    `BDPC_ASSERT_IMP(a_short_on_release, aclk, aresetn, m_valid && m_short_press, !m_pressed)
    `BDPC_ASSERT_NXT(a_advance_gives_result, aclk, aresetn, advance, m_valid)
    `BDPC_ASSERT_NXT(a_long_marks_fired, aclk, aresetn, advance && result_next.long_press, long_fired_reg)

endmodule

[bench/press_event_checker.sv]
// result checker for the button debounce press classifier bench
// depends on bdpc_pkg; tracks the config port, predicts each tick and compares results
module press_event_checker
    import bdpc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic                  s_raw_level,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic                  m_pressed,
    input  logic                  m_short_press,
    input  logic                  m_long_press,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output int                    mismatches,
    output int                    outstanding
);

    // shadow copy of the registers
    logic [DEBOUNCE_W-1:0]   quiet_limit;
    logic [LONG_PRESS_W-1:0] hold_limit;

    // shadow copy of the button tracking state
    logic                   prev_level;
    logic [COUNT_WIDTH-1:0] quiet_ticks;
    logic                   btn_down;
    logic [COUNT_WIDTH-1:0] held_ticks;
    logic                   long_seen;

    result_t expected_events[$];
    int      err_count = 0;

    // counter step that sticks at all ones
    function automatic logic [COUNT_WIDTH-1:0] bump(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    // advance the tracked state by one tick and return the event it causes
    function automatic result_t predict_tick(input logic level);
        result_t ev;
        logic    now_down;
        ev = '0;
        if (level != prev_level) begin
            prev_level  = level;
            quiet_ticks = '0;
        end else begin
            quiet_ticks = bump(quiet_ticks);
        end
        if (btn_down) begin
            held_ticks = bump(held_ticks);
        end
        // level has been quiet long enough to count
        if (quiet_ticks > quiet_limit) begin
            now_down = (prev_level == LOW);
            if (now_down && !btn_down) begin
                held_ticks = '0;
                long_seen  = 1'b0;
            end else if (!now_down && btn_down && !long_seen) begin
                ev.short_press = 1'b1;
            end
            btn_down = now_down;
        end
        // one long press per hold
        if (btn_down && !long_seen && held_ticks >= hold_limit) begin
            long_seen     = 1'b1;
            ev.long_press = 1'b1;
        end
        ev.pressed = btn_down;
        return ev;
    endfunction

    function automatic void check_field(input string field, input logic want, input logic got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0b, actual %0b", $time, field, want, got);
            err_count++;
        end
    endfunction

    // sample both channels and the config port at the rising edge
    always @(posedge aclk) begin : monitor
        result_t want;
        if (!aresetn) begin
            quiet_limit = DEBOUNCE_RESET;
            hold_limit  = LONG_PRESS_RESET;
            prev_level  = 1'b1;
            quiet_ticks = '0;
            btn_down    = 1'b0;
            held_ticks  = '0;
            long_seen   = 1'b0;
            expected_events.delete();
        end else begin
            // register writes, unknown indexes ignored
            if (cfg_we) begin
                case (cfg_index)
                    REG_DEBOUNCE_TICKS: begin
                        quiet_limit = cfg_wdata[DEBOUNCE_W-1:0];
                    end
                    REG_LONG_PRESS_TICKS: begin
                        hold_limit = cfg_wdata[LONG_PRESS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            // result transaction against the oldest expectation
            if (m_valid && m_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result: pressed %0b short %0b long %0b",
                             $time, m_pressed, m_short_press, m_long_press);
                    err_count++;
                end else begin
                    want = expected_events.pop_front();
                    check_field("pressed", want.pressed, m_pressed);
                    check_field("short_press", want.short_press, m_short_press);
                    check_field("long_press", want.long_press, m_long_press);
                end
            end
            // input transaction
            if (s_valid && s_ready) begin
                expected_events.push_back(predict_tick(s_raw_level));
            end
        end
        mismatches  = err_count;
        outstanding = expected_events.size();
    end

endmodule

[bench/tb_button_debounce_press_classifier.sv]
// testbench top for the button debounce press classifier
// depends on bdpc_pkg, button_debounce_press_classifier and press_event_checker
module tb_button_debounce_press_classifier;
    import bdpc_pkg::*;

    localparam int COUNT_WIDTH = 16;
    localparam int RANDOM_TICKS = 260;
    localparam int CYCLE_LIMIT = 4000000;

    // indexes past the register list, writes must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_raw_level;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_pressed;
    logic                  m_short_press;
    logic                  m_long_press;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    int mismatches;
    int outstanding;

    int unsigned burst_left = 0;
    int unsigned ticks_sent = 0;
    int unsigned cycle_cnt = 0;
    int unsigned cur_deb;
    int unsigned cur_lp;
    int unsigned phase_end;
    int unsigned pick;
    logic [CFG_DATA_W-1:0] wval;

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    button_debounce_press_classifier #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_level   (s_raw_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pressed     (m_pressed),
        .m_short_press (m_short_press),
        .m_long_press  (m_long_press),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    press_event_checker #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_raw_level   (s_raw_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pressed     (m_pressed),
        .m_short_press (m_short_press),
        .m_long_press  (m_long_press),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    // one tick transaction, sent in bursts with random gaps; called at a falling edge
    task automatic send_tick(input logic lvl);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_raw_level <= lvl;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        ticks_sent++;
    endtask

    task automatic drive_run(input logic lvl, input int unsigned n);
        repeat (n) send_tick(lvl);
    endtask

    // config write, one cycle of write enable, then write enable dropped before returning
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // stop offering and let every expected result arrive
    task automatic wait_drained();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (outstanding != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // short runs of alternating level that stay under the quiet time
    task automatic bounce(input int unsigned deb);
        int unsigned n;
        int unsigned k;
        n = $urandom_range(0, 3);
        for (k = 0; k < n; k++) begin
            drive_run(1'b0, $urandom_range(1, (deb > 0) ? deb : 1));
            drive_run(1'b1, $urandom_range(1, (deb > 0) ? deb : 1));
        end
    endtask

    // bounce, held press, bounce, release; the shortest press or release run falls one tick short of acceptance
    task automatic press_sequence(input int unsigned deb, input int unsigned lp);
        int unsigned held;
        held = deb + 1 + ((lp > 40) ? $urandom_range(0, 40) : $urandom_range(0, lp + 6));
        bounce(deb);
        drive_run(1'b0, held);
        bounce(deb);
        drive_run(1'b1, deb + 1 + $urandom_range(0, 8));
    endtask

    // receiver: changing stall patterns plus a periodic long hold-off
    initial begin : receiver
        int unsigned rx_cycle;
        int unsigned rx_mode;
        int unsigned hold_off;
        logic [7:0]  rx_mask;
        rx_cycle = 0;
        rx_mode  = 0;
        hold_off = 0;
        rx_mask  = 8'h01;
        m_ready  = 1'b0;
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (hold_off > 0) begin
                hold_off--;
                m_ready <= 1'b0;
            end else if (rx_cycle % 2500 == 400) begin
                hold_off = 80;
                m_ready <= 1'b0;
            end else begin
                if (rx_cycle % 64 == 0) begin
                    rx_mode = $urandom_range(0, 3);
                    rx_mask = 8'($urandom_range(1, 255));
                end
                rx_mask = {rx_mask[6:0], rx_mask[7]};
                case (rx_mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= rx_mask[0];
                endcase
            end
        end
    end

    // timeout
    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // stimulus and verdict
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_raw_level = 1'b1;
        cfg_we      = 1'b0;
        cfg_index   = REG_DEBOUNCE_TICKS;
        cfg_wdata   = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values: a short press-like blip is far under the quiet time
        drive_run(1'b0, 3);
        drive_run(1'b1, 2);
        wait_drained();

        // zero quiet time and zero long press time, upper data bits masked off
        write_reg(REG_DEBOUNCE_TICKS, 16'hAB00);
        write_reg(REG_LONG_PRESS_TICKS, 16'h0000);
        write_reg(REG_UNUSED_2, 16'hFFFF);
        write_reg(REG_UNUSED_3, 16'hFFFF);
        drive_run(1'b0, 3);
        drive_run(1'b1, 3);
        wait_drained();

        // long press time lowered while the hold is counting
        write_reg(REG_DEBOUNCE_TICKS, 16'd1);
        write_reg(REG_LONG_PRESS_TICKS, 16'd200);
        drive_run(1'b0, 6);
        wait_drained();
        write_reg(REG_LONG_PRESS_TICKS, 16'd2);
        drive_run(1'b0, 4);
        drive_run(1'b1, 4);
        wait_drained();

        // random phases, each with its own register setting
        phase_end = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < phase_end) begin
            pick = $urandom_range(0, 9);
            cur_deb = (pick < 6) ? $urandom_range(0, 4) :
                      (pick < 9) ? $urandom_range(5, 12) : 0;
            pick = $urandom_range(0, 9);
            cur_lp = (pick < 7) ? $urandom_range(0, 25) :
                     (pick < 9) ? $urandom_range(26, 60) : 16'hFFFF;
            wval = CFG_DATA_W'($urandom);
            wval[DEBOUNCE_W-1:0] = cur_deb[DEBOUNCE_W-1:0];
            write_reg(REG_DEBOUNCE_TICKS, wval);
            write_reg(REG_LONG_PRESS_TICKS, cur_lp[LONG_PRESS_W-1:0]);
            if ($urandom_range(0, 3) == 0) begin
                write_reg($urandom_range(0, 1) ? REG_UNUSED_2 : REG_UNUSED_3,
                          CFG_DATA_W'($urandom));
            end
            pick = ticks_sent + $urandom_range(50, 90);
            while (ticks_sent < pick) begin
                if ($urandom_range(0, 9) < 8) begin
                    press_sequence(cur_deb, cur_lp);
                end else begin
                    repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)));
                end
            end
            wait_drained();
        end

        // largest register values: runs shorter than the quiet time are never accepted
        write_reg(REG_DEBOUNCE_TICKS, 16'h00FF);
        write_reg(REG_LONG_PRESS_TICKS, 16'hFFFF);
        drive_run(1'b0, 60);
        drive_run(1'b1, 40);
        wait_drained();

        repeat (10) @(negedge aclk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
